### rtl/gqvs_pkg.sv
// shared types and constants for the glyph quad vertex setup block
`default_nettype none

package gqvs_pkg;

   // fixed field widths
   localparam int VIEWPORT_W = 15;
   localparam int NUM_W      = 20;
   localparam int TEX_W      = 15;
   localparam int QUOT_W     = 16;
   localparam int CSR_IDX_W  = 1;

   // one in the NDC fixed point format
   localparam logic [16:0] NDC_ONE = 17'd16384;

   // results of one accepted glyph
   localparam logic [3:0] VALID_RESULTS = 4'd10;
   localparam logic [3:0] LAST_RESULT   = 4'd9;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VIEWPORT_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEWPORT_HEIGHT = 1'd1;

   // result record kinds
   localparam logic [1:0] KIND_VERTEX  = 2'd0;
   localparam logic [1:0] KIND_INDEX   = 2'd1;
   localparam logic [1:0] KIND_INVALID = 2'd2;

   typedef struct packed {
      logic               start_of_list;
      logic [15:0]        list_position;
      logic signed [19:0] rect_x;
      logic signed [19:0] rect_y;
      logic signed [19:0] rect_w;
      logic signed [19:0] rect_h;
      logic signed [15:0] tex_x;
      logic signed [15:0] tex_y;
      logic signed [15:0] tex_w;
      logic signed [15:0] tex_h;
      logic [31:0]        glyph_color;
   } req_type;

   typedef struct packed {
      logic [1:0]         record_kind;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [14:0]        tex_u;
      logic [14:0]        tex_v;
      logic [31:0]        vertex_color;
      logic [31:0]        index_value;
      logic [15:0]        item_index;
      logic               last_of_glyph;
   } rsp_type;

   // classified glyph handed from the front to the back
   typedef struct packed {
      logic             start;
      logic             bad;
      logic [15:0]      item_index;
      logic [31:0]      color;
      logic [NUM_W-1:0] x_lo;
      logic [NUM_W-1:0] x_hi;
      logic [NUM_W-1:0] y_lo;
      logic [NUM_W-1:0] y_hi;
      logic [TEX_W-1:0] u_lo;
      logic [TEX_W-1:0] u_hi;
      logic [TEX_W-1:0] v_lo;
      logic [TEX_W-1:0] v_hi;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

### rtl/glyph_quad_vertex_setup.sv
// Glyph quad vertex setup: turns glyph rectangles into quad vertices and indices.
// Input channel: req_push / req_full with one glyph per beat on req_data.
// Result channel: rsp_empty / rsp_pop; the oldest record sits on rsp_data while
// rsp_empty is low. A valid glyph gives four vertex records then six index
// records; a rejected glyph gives a single diagnostic record.
// Configuration: csr_write_enable, csr_index, csr_write_data; width is index 0,
// height index 1. The user must write them only while the block is idle; the
// block itself does not enforce this.
// The four corner divisions run in parallel, one quotient bit per cycle, while
// the back end waits in its divide state; a rejected glyph skips the division
// and goes straight to its diagnostic.
// A two-entry job queue lets new glyphs be accepted while the back end works;
// req_full rises once it holds two glyphs.
// When the receiver stalls, the result register holds its beat and the back
// end pauses; the queue then fills and req_full stops the sender.
// Reset empties the queue and result register, clears the vertex base and
// sets the viewport to 640 by 480.
`default_nettype none

module glyph_quad_vertex_setup #(
   parameter int COORD_FRAC_BITS = 4,
   parameter int TEX_FRAC_BITS   = 14
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire gqvs_pkg::req_type               req_data,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output gqvs_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_write_enable,
   input  wire logic [gqvs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gqvs_pkg::VIEWPORT_W-1:0] csr_write_data
);
   import gqvs_pkg::*;

   logic [VIEWPORT_W-1:0] vp_width_ff;
   logic [VIEWPORT_W-1:0] vp_width_in;
   logic [VIEWPORT_W-1:0] vp_height_ff;
   logic [VIEWPORT_W-1:0] vp_height_in;
   job_type               front_job;
   job_type               q_data;
   logic                  q_empty;
   logic                  q_pop;

   // configuration registers
   always_comb begin
      vp_width_in  = vp_width_ff;
      vp_height_in = vp_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_VIEWPORT_WIDTH:  vp_width_in  = csr_write_data;
            CSR_VIEWPORT_HEIGHT: vp_height_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_width_ff  <= VIEWPORT_W'(640);
         vp_height_ff <= VIEWPORT_W'(480);
      end else begin
         vp_width_ff  <= vp_width_in;
         vp_height_ff <= vp_height_in;
      end
   end

   // classify incoming glyphs
   gqvs_front #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS),
      .TEX_FRAC_BITS  (TEX_FRAC_BITS)
   ) u_front (
      .req      (req_data),
      .vp_width (vp_width_ff),
      .vp_height(vp_height_ff),
      .job      (front_job)
   );

   // job queue between front and back
   gqvs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_data(front_job),
      .full     (req_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_data (q_data)
   );

   // division and record sequencing
   gqvs_back #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .vp_width (vp_width_ff),
      .vp_height(vp_height_ff),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/gqvs_front.sv
// front part: range checks and edge sums for one glyph
`default_nettype none

module gqvs_front #(
   parameter int COORD_FRAC_BITS = 4,
   parameter int TEX_FRAC_BITS   = 14
) (
   input  wire gqvs_pkg::req_type                     req,
   input  wire logic [gqvs_pkg::VIEWPORT_W-1:0]       vp_width,
   input  wire logic [gqvs_pkg::VIEWPORT_W-1:0]       vp_height,
   output gqvs_pkg::job_type                          job
);
   import gqvs_pkg::*;

   localparam int DEN_W = VIEWPORT_W + COORD_FRAC_BITS;
   localparam int CMP_W = ((DEN_W > NUM_W) ? DEN_W : NUM_W) + 1;
   localparam int TSUM_W = TEX_W + 1;
   localparam int TCMP_W = ((TSUM_W > TEX_FRAC_BITS + 1) ? TSUM_W : TEX_FRAC_BITS + 1) + 1;

   logic [DEN_W-1:0]  vw;
   logic [DEN_W-1:0]  vh;
   logic [NUM_W-1:0]  x_sum;
   logic [NUM_W-1:0]  y_sum;
   logic [TSUM_W-1:0] u_sum;
   logic [TSUM_W-1:0] v_sum;
   logic [TCMP_W-1:0] tex_one;
   logic              neg_any;
   logic              over_view;
   logic              over_tex;
   logic              zero_view;

   // viewport in pixel fixed point
   assign vw = DEN_W'(vp_width) << COORD_FRAC_BITS;
   assign vh = DEN_W'(vp_height) << COORD_FRAC_BITS;
   assign tex_one = TCMP_W'(1) << TEX_FRAC_BITS;

   // far edges, only meaningful once the signs have passed
   assign x_sum = NUM_W'(req.rect_x[18:0]) + NUM_W'(req.rect_w[18:0]);
   assign y_sum = NUM_W'(req.rect_y[18:0]) + NUM_W'(req.rect_h[18:0]);
   assign u_sum = TSUM_W'(req.tex_x[14:0]) + TSUM_W'(req.tex_w[14:0]);
   assign v_sum = TSUM_W'(req.tex_y[14:0]) + TSUM_W'(req.tex_h[14:0]);

   // rejection checks
   assign zero_view = (vp_width == '0) || (vp_height == '0);
   assign neg_any = req.rect_x[19] | req.rect_y[19] | req.rect_w[19] | req.rect_h[19] |
                    req.tex_x[15] | req.tex_y[15] | req.tex_w[15] | req.tex_h[15];
   assign over_view = (CMP_W'(x_sum) > CMP_W'(vw)) || (CMP_W'(y_sum) > CMP_W'(vh));
   assign over_tex = (TCMP_W'(u_sum) > tex_one) || (TCMP_W'(v_sum) > tex_one);

   // classified job
   always_comb begin
      job.start      = req.start_of_list;
      job.bad        = zero_view | neg_any | over_view | over_tex;
      job.item_index = req.list_position;
      job.color      = req.glyph_color;
      job.x_lo       = NUM_W'(req.rect_x[18:0]);
      job.x_hi       = x_sum;
      job.y_lo       = NUM_W'(req.rect_y[18:0]);
      job.y_hi       = y_sum;
      job.u_lo       = req.tex_x[14:0];
      job.u_hi       = u_sum[TEX_W-1:0];
      job.v_lo       = req.tex_y[14:0];
      job.v_hi       = v_sum[TEX_W-1:0];
   end

endmodule

`default_nettype wire

### rtl/gqvs_queue.sv
// two-entry queue between the front and the back
`default_nettype none

module gqvs_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire gqvs_pkg::job_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   empty,
   output gqvs_pkg::job_type      pop_data
);
   import gqvs_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   job_type              slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_in;
   logic [PTR_W:0]       count_ff;
   logic [PTR_W:0]       count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/gqvs_div.sv
// restoring divider, one quotient bit per cycle, for numerators not above the divisor
`default_nettype none

module gqvs_div #(
   parameter int DEN_W = 19
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [gqvs_pkg::NUM_W-1:0]   num,
   input  wire logic [DEN_W-1:0]             den,
   output logic                              busy,
   output logic [gqvs_pkg::QUOT_W-1:0]       quot,
   output logic                              inexact
);
   import gqvs_pkg::*;

   localparam int REM_W  = ((DEN_W > NUM_W) ? DEN_W : NUM_W) + 1;
   localparam int STEP_W = $clog2(QUOT_W);

   logic [REM_W-1:0]  rem_ff;
   logic [REM_W-1:0]  rem_in;
   logic [QUOT_W-1:0] quot_ff;
   logic [QUOT_W-1:0] quot_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              run_ff;
   logic              run_in;
   logic [REM_W-1:0]  trial;
   logic              fits;

   // first step takes the integer bit, the rest shift in zeros
   assign trial = (step_ff == '0) ? rem_ff : (rem_ff << 1);
   assign fits  = (trial >= REM_W'(den));

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      run_in  = run_ff;
      if (start) begin
         rem_in  = REM_W'(num);
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rem_in  = fits ? trial - REM_W'(den) : trial;
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         step_in = step_ff + 1'b1;
         run_in  = (step_ff != STEP_W'(QUOT_W - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign busy    = run_ff;
   assign quot    = quot_ff;
   assign inexact = (rem_ff != '0);

endmodule

`default_nettype wire

### rtl/gqvs_back.sv
// back part: corner division, vertex and index sequencing, result register
`default_nettype none

module gqvs_back #(
   parameter int COORD_FRAC_BITS = 4
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_empty,
   input  wire gqvs_pkg::job_type               q_data,
   output logic                                 q_pop,
   input  wire logic [gqvs_pkg::VIEWPORT_W-1:0] vp_width,
   input  wire logic [gqvs_pkg::VIEWPORT_W-1:0] vp_height,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output gqvs_pkg::rsp_type                    rsp_data
);
   import gqvs_pkg::*;

   localparam int DEN_W = VIEWPORT_W + COORD_FRAC_BITS;

   state_type         state_ff;
   state_type         state_in;
   job_type           job_ff;
   job_type           job_in;
   logic [31:0]       base_ff;
   logic [31:0]       base_in;
   logic [3:0]        cnt_ff;
   logic [3:0]        cnt_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   rsp_type           out_ff;
   rsp_type           out_in;
   rsp_type           rec;
   logic              div_start;
   logic              slot_free;
   logic [DEN_W-1:0]  dw;
   logic [DEN_W-1:0]  dh;
   logic [3:0]        busy;
   logic [QUOT_W-1:0] q_l;
   logic [QUOT_W-1:0] q_r;
   logic [QUOT_W-1:0] q_t;
   logic [QUOT_W-1:0] q_b;
   logic [3:0]        inexact;
   logic [15:0]       ndc_l;
   logic [15:0]       ndc_r;
   logic [15:0]       ndc_t;
   logic [15:0]       ndc_b;

   assign dw = DEN_W'(vp_width) << COORD_FRAC_BITS;
   assign dh = DEN_W'(vp_height) << COORD_FRAC_BITS;

   // four corner dividers working side by side
   gqvs_div #(.DEN_W(DEN_W)) u_div_l (
      .clock(clock), .reset(reset), .start(div_start), .num(q_data.x_lo), .den(dw),
      .busy(busy[0]), .quot(q_l), .inexact(inexact[0])
   );
   gqvs_div #(.DEN_W(DEN_W)) u_div_r (
      .clock(clock), .reset(reset), .start(div_start), .num(q_data.x_hi), .den(dw),
      .busy(busy[1]), .quot(q_r), .inexact(inexact[1])
   );
   gqvs_div #(.DEN_W(DEN_W)) u_div_t (
      .clock(clock), .reset(reset), .start(div_start), .num(q_data.y_lo), .den(dh),
      .busy(busy[2]), .quot(q_t), .inexact(inexact[2])
   );
   gqvs_div #(.DEN_W(DEN_W)) u_div_b (
      .clock(clock), .reset(reset), .start(div_start), .num(q_data.y_hi), .den(dh),
      .busy(busy[3]), .quot(q_b), .inexact(inexact[3])
   );

   // ndc: x floors the quotient, y takes the ceiling before negating
   always_comb begin
      ndc_l = 16'(17'(q_l) - NDC_ONE);
      ndc_r = 16'(17'(q_r) - NDC_ONE);
      ndc_t = 16'(NDC_ONE - (17'(q_t) + 17'(inexact[2])));
      ndc_b = 16'(NDC_ONE - (17'(q_b) + 17'(inexact[3])));
   end

   // record for the current sequence position
   always_comb begin
      rec = '0;
      if (job_ff.bad) begin
         rec.record_kind   = KIND_INVALID;
         rec.item_index    = job_ff.item_index;
         rec.last_of_glyph = 1'b1;
      end else begin
         case (cnt_ff) inside
            4'd0, 4'd1, 4'd2, 4'd3: begin
               rec.record_kind  = KIND_VERTEX;
               rec.vertex_color = job_ff.color;
               rec.pos_x = (cnt_ff == 4'd0 || cnt_ff == 4'd3) ? ndc_l : ndc_r;
               rec.pos_y = (cnt_ff == 4'd0 || cnt_ff == 4'd1) ? ndc_t : ndc_b;
               rec.tex_u = (cnt_ff == 4'd0 || cnt_ff == 4'd3) ? job_ff.u_lo : job_ff.u_hi;
               rec.tex_v = (cnt_ff == 4'd0 || cnt_ff == 4'd1) ? job_ff.v_lo : job_ff.v_hi;
            end
            4'd4, 4'd7: begin
               rec.record_kind = KIND_INDEX;
               rec.index_value = base_ff;
            end
            4'd5: begin
               rec.record_kind = KIND_INDEX;
               rec.index_value = base_ff + 32'd1;
            end
            4'd6, 4'd8: begin
               rec.record_kind = KIND_INDEX;
               rec.index_value = base_ff + 32'd2;
            end
            default: begin
               rec.record_kind   = KIND_INDEX;
               rec.index_value   = base_ff + 32'd3;
               rec.last_of_glyph = 1'b1;
            end
         endcase
      end
   end

   assign slot_free = ~out_valid_ff | rsp_pop;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      out_in       = out_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               job_in = q_data;
               cnt_in = '0;
               if (q_data.start) begin
                  base_in = '0;
               end
               if (q_data.bad) begin
                  state_in = ST_EMIT;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (busy == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_in       = rec;
               cnt_in       = cnt_ff + 1'b1;
               if (rec.last_of_glyph) begin
                  state_in = ST_IDLE;
                  if (!job_ff.bad) begin
                     base_in = base_ff + 32'd4;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      out_ff <= out_in;
   end

   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_ff;

   // sequence position never runs past the last result
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (cnt_ff < VALID_RESULTS))
      else $error("emit position out of range");

   // a waiting beat is never overwritten
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> (out_valid_ff && $stable(out_ff)))
      else $error("waiting result beat overwritten");

   // jobs are taken only while the sequencer is idle
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE && !q_empty))
      else $error("job taken outside idle");

   // a diagnostic always closes its glyph
   a_diag_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.record_kind == KIND_INVALID) |-> out_ff.last_of_glyph)
      else $error("diagnostic without last flag");

   // dividers only run while waiting on them
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      (busy != '0) |-> (state_ff == ST_DIVIDE))
      else $error("divider busy outside divide state");

endmodule

`default_nettype wire
